// ----- sv/base64_stream_encoder_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Plain clocked property, masked during reset.
`define B64E_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A stalled beat keeps its payload.
`define B64E_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/b64e_pkg.sv -----
`default_nettype none
package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
        logic       message_end;
    } t_out_beat;

    // one output symbol: a sextet or an '=' pad
    typedef struct packed {
        logic       is_pad;
        logic [5:0] sextet;
    } t_sym;

    // work for one byte: up to four symbols, index of the last one
    typedef struct packed {
        t_sym [3:0] sym;
        logic [1:0] last_idx;
        logic       fin;
    } t_job;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR     = 7'h3D;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
        logic [6:0] v7;
        logic [6:0] res;
        v7 = {1'b0, v};
        priority if (v < 6'd26) begin
            res = CHAR_UPPER_A + v7;
        end else if (v < 6'd52) begin
            res = CHAR_LOWER_A + v7 - 7'd26;
        end else if (v < 6'd62) begin
            res = CHAR_DIGIT_0 + v7 - 7'd52;
        end else if (v == 6'd62) begin
            res = CHAR_PLUS;
        end else begin
            res = CHAR_SLASH;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- sv/b64e_front.sv -----
`default_nettype none
module b64e_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire b64e_pkg::t_in_beat i_data,
    output logic                   o_push,
    output b64e_pkg::t_job         o_job,
    input  wire logic              i_full
);
    import b64e_pkg::*;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [7:0] b;
    logic       fin;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign b       = i_data.data_byte;
    assign fin     = i_data.final_byte;

    always_comb begin
        o_job     = '0;
        o_job.fin = fin;
        n_phase   = r_phase;
        n_left    = r_left;
        unique case (r_phase)
            PH_1: begin
                o_job.sym[0].sextet = {r_left[1:0], b[7:4]};
                if (fin) begin
                    o_job.sym[1].sextet = {b[3:0], 2'b00};
                    o_job.sym[2].is_pad = 1'b1;
                    o_job.last_idx      = 2'd2;
                end else begin
                    n_left  = b[3:0];
                    n_phase = PH_2;
                end
            end
            PH_2: begin
                o_job.sym[0].sextet = {r_left, b[7:6]};
                o_job.sym[1].sextet = b[5:0];
                o_job.last_idx      = 2'd1;
                n_left              = '0;
                n_phase             = PH_0;
            end
            default: begin // phase 0, and the unused code
                o_job.sym[0].sextet = b[7:2];
                if (fin) begin
                    o_job.sym[1].sextet = {b[1:0], 4'b0000};
                    o_job.sym[2].is_pad = 1'b1;
                    o_job.sym[3].is_pad = 1'b1;
                    o_job.last_idx      = 2'd3;
                end else begin
                    n_left  = {2'b00, b[1:0]};
                    n_phase = PH_1;
                end
            end
        endcase
        if (fin) begin
            n_phase = PH_0;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

// ----- sv/b64e_queue.sv -----
`default_nettype none
module b64e_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire b64e_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_nonempty,
    output b64e_pkg::t_job     o_job
);
    import b64e_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full     = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/b64e_back.sv -----
`default_nettype none
module b64e_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire b64e_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output b64e_pkg::t_out_beat o_data
);
    import b64e_pkg::*;

    logic      [1:0] r_idx;
    logic            r_valid;
    t_out_beat       r_data;
    logic            load, take, last;
    t_sym            sym;
    t_out_beat       n_data;

    assign load = !r_valid || i_ready;
    assign take = load && i_job_valid;
    assign sym  = i_job.sym[r_idx];
    assign last = (r_idx == i_job.last_idx);
    assign o_pop = take && last;

    always_comb begin
        n_data.out_char    = sym.is_pad ? PAD_CHAR : sextet_to_ascii(sym.sextet);
        n_data.run_last    = last;
        n_data.message_end = last && i_job.fin;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= i_job_valid;
            end
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ----- sv/base64_stream_encoder.sv -----
// Streaming base64 encoder, standard alphabet with '=' padding. Feed one message byte per
// input beat, with final_byte set on the last one; each output beat carries one ASCII
// character, run_last marks the last character a byte produced and message_end marks the
// last character of the message. Output runs one character per cycle while i_ready is
// high and a job is queued; a byte produces one or two characters mid-message and up to
// four on a final byte, so steady streaming yields four characters per three bytes. The
// front end takes a byte every cycle while its two-entry job queue has room, so bursts
// are absorbed; jobs are registered in the queue and characters in the output register.
`default_nettype none
module base64_stream_encoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire b64e_pkg::t_in_beat  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output b64e_pkg::t_out_beat     o_data
);
    import b64e_pkg::*;

    logic push, full, pop, nonempty;
    t_job push_job, head_job;

    // front: tracks group phase and leftover bits, splits each byte into symbols
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // decouples byte intake from character output
    b64e_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_job      (head_job)
    );

    // back: one character per beat from the head job, registered output
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (nonempty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

// ----- sv/b64e_checker.sv -----
`default_nettype none
`include "base64_stream_encoder_macros.svh"
module b64e_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire b64e_pkg::t_in_beat   i_data,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire b64e_pkg::t_out_beat  o_data
);
    import b64e_pkg::*;

    `B64E_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid, i_ready, o_data, "stalled beat changed")
    `B64E_ASSERT(a_end_is_run_last, i_clk, i_rst_n, (o_valid && o_data.message_end) |-> o_data.run_last, "message_end without run_last")
    `B64E_ASSERT(a_pad_ends_msg, i_clk, i_rst_n, (o_valid && o_data.out_char == PAD_CHAR && o_data.run_last) |-> o_data.message_end, "pad closes a run mid-message")
    `B64E_ASSERT(a_idle_after_rst, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_valid, "output valid straight after reset")

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);
`default_nettype wire
